// ===== rtl/c5ta_pkg.sv =====
package c5ta_pkg;

    localparam int KERN_SIZE = 5;
    localparam int KC        = KERN_SIZE / 2;

    localparam int PIX_W     = 8;
    localparam int GEO_W     = 9;
    localparam int OROW_W    = 8;
    localparam int COEF_W    = 2;
    localparam int COEFS_W   = 50;

    localparam int MAX_HEIGHT      = 256;
    localparam int FRAME_WIDTH_RST = 256;

    // Arithmetic widths: one tap is in -510..255, a row of five taps in
    // -2550..1275, the full window in -12750..6375.
    localparam int PROD_W = 10;
    localparam int RSUM_W = 13;
    localparam int TSUM_W = 15;
    localparam int ABS_W  = 14;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    localparam int REG_LSB = 3;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_KERNEL_COEFFS = 2'd2
    } t_reg_idx;

    // Window element [k][j] holds the pixel k rows and j columns behind the newest one.
    typedef logic [KERN_SIZE-1:0][KERN_SIZE-1:0][PIX_W-1:0] t_win;

    // One line buffer word: the same column of the previous KERN_SIZE-1 rows.
    typedef logic [KERN_SIZE-2:0][PIX_W-1:0] t_lb_word;

    typedef struct packed {
        logic [KERN_SIZE-1:0] row_ok;
        logic [KERN_SIZE-1:0] col_ok;
        logic                 last;
    } t_tag;

endpackage

// ===== rtl/c5ta_ram.sv =====
module c5ta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/c5ta_linebuf.sv =====
module c5ta_linebuf import c5ta_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_lb_word                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_lb_word                 o_rdata
);

    logic     [$bits(t_lb_word)-1:0] ram_q;
    logic                            r_fwd;
    t_lb_word                        r_fwd_word;

    c5ta_ram #(
        .WIDTH ($bits(t_lb_word)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    // The RAM returns old data when a column is written and read in the same
    // cycle, which happens on every beat of a one-pixel-wide frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_we && (i_waddr == i_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_word <= i_wdata;
    end

    assign o_rdata = r_fwd ? r_fwd_word : t_lb_word'(ram_q);

endmodule

// ===== rtl/c5ta_window.sv =====
module c5ta_window import c5ta_pkg::*; #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_width,
    input  logic [GEO_W-1:0]               i_height,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [PIX_W-1:0]               i_pixel_in,
    input  logic                           i_flush,
    output logic                           o_valid,
    input  logic                           i_ready,
    output t_win                           o_win,
    output t_tag                           o_tag
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int WX = WW + 1;
    localparam int DW = $clog2(KC * MAX_WIDTH + KC + 1);

    logic [DW-1:0]     r_cnt,  n_cnt;
    logic [CW-1:0]     r_icol, n_icol;
    logic [GEO_W-1:0]  r_irow, n_irow;
    logic [CW-1:0]     r_ocol, n_ocol;
    logic [OROW_W-1:0] r_orow, n_orow;
    logic              r_s1_v, n_s1_v;
    t_win              r_win,  n_win;
    t_tag              r_tag,  n_tag;

    logic [DW-1:0]      delay;
    logic               accept;
    logic               active;
    logic               in_last_col;
    logic               out_last_col;
    logic               out_last_row;
    logic               frame_end;
    logic [PIX_W-1:0]   col_in [KERN_SIZE];
    logic [KERN_SIZE-1:0] row_ok;
    logic [KERN_SIZE-1:0] col_ok;
    t_lb_word           lb_wdata;
    t_lb_word           lb_rdata;

    assign o_ready = !r_s1_v || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        // The result for a pixel leaves with the beat KC rows and KC columns later.
        delay        = DW'(i_width) * DW'(KC) + DW'(KC);
        active       = (r_cnt >= delay);
        in_last_col  = (WW'(r_icol) == i_width - WW'(1));
        out_last_col = (WW'(r_ocol) == i_width - WW'(1));
        out_last_row = (GEO_W'(r_orow) == i_height - GEO_W'(1));
        frame_end    = active && out_last_col && out_last_row;

        // Beats past the last pixel of the frame shift in zeros.
        col_in[0] = ((r_irow < i_height) && !i_flush) ? i_pixel_in : '0;
        for (int k = 1; k < KERN_SIZE; k++) begin
            col_in[k] = lb_rdata[k-1];
        end
        for (int e = 0; e < KERN_SIZE - 1; e++) begin
            lb_wdata[e] = col_in[e];
        end

        for (int m = 0; m < KERN_SIZE; m++) begin
            if (m < KC) begin
                row_ok[m] = (GEO_W'(r_orow) >= GEO_W'(KC - m));
                col_ok[m] = (WX'(r_ocol) >= WX'(KC - m));
            end else begin
                row_ok[m] = (GEO_W'(r_orow) + GEO_W'(m - KC) < i_height);
                col_ok[m] = (WX'(r_ocol) + WX'(m - KC) < WX'(i_width));
            end
        end

        n_cnt  = r_cnt;
        n_icol = r_icol;
        n_irow = r_irow;
        n_ocol = r_ocol;
        n_orow = r_orow;
        n_win  = r_win;
        n_tag  = r_tag;
        n_s1_v = r_s1_v;

        if (o_ready) begin
            n_s1_v = accept && active;
        end

        if (accept) begin
            for (int k = 0; k < KERN_SIZE; k++) begin
                n_win[k][0] = col_in[k];
                for (int j = 1; j < KERN_SIZE; j++) begin
                    n_win[k][j] = r_win[k][j-1];
                end
            end
            n_tag.row_ok = row_ok;
            n_tag.col_ok = col_ok;
            n_tag.last   = frame_end;

            if (frame_end) begin
                n_cnt  = '0;
                n_icol = '0;
                n_irow = '0;
                n_ocol = '0;
                n_orow = '0;
            end else begin
                if (!active) begin
                    n_cnt = r_cnt + DW'(1);
                end
                if (in_last_col) begin
                    n_icol = '0;
                    n_irow = r_irow + GEO_W'(1);
                end else begin
                    n_icol = r_icol + CW'(1);
                end
                if (active) begin
                    if (out_last_col) begin
                        n_ocol = '0;
                        n_orow = r_orow + OROW_W'(1);
                    end else begin
                        n_ocol = r_ocol + CW'(1);
                    end
                end
            end
        end
    end

    // The read address tracks the column of the next beat, so the word for a
    // beat is already in the read register when that beat arrives.
    c5ta_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept),
        .i_waddr (r_icol),
        .i_wdata (lb_wdata),
        .i_raddr (n_icol),
        .o_rdata (lb_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_icol <= '0;
            r_irow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_icol <= n_icol;
            r_irow <= n_irow;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
            r_s1_v <= n_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_tag <= n_tag;
    end

    assign o_valid = r_s1_v;
    assign o_win   = r_win;
    assign o_tag   = r_tag;

    a_frame_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && frame_end |=> (r_cnt == '0) && (r_icol == '0) && (r_irow == '0)
                                && (r_ocol == '0) && (r_orow == '0))
        else $error("position counters did not return to zero after the last pixel");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !i_ready |=> r_s1_v && $stable(r_tag))
        else $error("window stage changed while the next stage was stalled");

endmodule

// ===== rtl/c5ta_mac.sv =====
module c5ta_mac import c5ta_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COEFS_W-1:0] i_coeffs,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_win               i_win,
    input  t_tag               i_tag,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pixel_out,
    output logic               o_clipped,
    output logic               o_frame_last
);

    function automatic logic signed [PROD_W-1:0] tap_prod(
        input logic [PIX_W-1:0]  px,
        input logic [COEF_W-1:0] code
    );
        logic signed [PIX_W+COEF_W:0] full;
        full = $signed({1'b0, px}) * $signed(code);
        return full[PROD_W-1:0];
    endfunction

    logic signed [RSUM_W-1:0] n_rsum [KERN_SIZE];
    logic signed [RSUM_W-1:0] r_rsum [KERN_SIZE];
    logic                     r_s2_v;
    logic                     r_s2_last;

    logic signed [TSUM_W-1:0] tsum;
    logic [ABS_W-1:0]         abs_sum;
    logic                     n_clip;
    logic [PIX_W-1:0]         n_pix;

    logic                     r_o_v;
    logic [PIX_W-1:0]         r_o_pix;
    logic                     r_o_clip;
    logic                     r_o_last;

    logic                     out_ready;
    logic                     s2_ready;

    assign out_ready = !r_o_v || i_ready;
    assign s2_ready  = !r_s2_v || out_ready;
    assign o_ready   = s2_ready;

    // Window row k, column j meets the kernel entry k*KERN_SIZE+j; this is the
    // flipped kernel laid over the pixels around the center.
    always_comb begin
        for (int k = 0; k < KERN_SIZE; k++) begin
            n_rsum[k] = '0;
            for (int j = 0; j < KERN_SIZE; j++) begin
                if (i_tag.row_ok[KERN_SIZE-1-k] && i_tag.col_ok[KERN_SIZE-1-j]) begin
                    n_rsum[k] = n_rsum[k] + RSUM_W'(tap_prod(i_win[k][j],
                        i_coeffs[COEF_W*(k*KERN_SIZE+j) +: COEF_W]));
                end
            end
        end
    end

    always_comb begin
        tsum = '0;
        for (int k = 0; k < KERN_SIZE; k++) begin
            tsum = tsum + TSUM_W'(r_rsum[k]);
        end
        abs_sum = tsum[TSUM_W-1] ? ABS_W'(-tsum) : ABS_W'(tsum);
        n_clip  = (abs_sum > ABS_W'({PIX_W{1'b1}}));
        n_pix   = n_clip ? {PIX_W{1'b1}} : abs_sum[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_v <= i_valid;
            end
            if (out_ready) begin
                r_o_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_rsum    <= n_rsum;
            r_s2_last <= i_tag.last;
        end
        if (out_ready && r_s2_v) begin
            r_o_pix  <= n_pix;
            r_o_clip <= n_clip;
            r_o_last <= r_s2_last;
        end
    end

    assign o_valid      = r_o_v;
    assign o_pixel_out  = r_o_pix;
    assign o_clipped    = r_o_clip;
    assign o_frame_last = r_o_last;

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> (o_pixel_out == {PIX_W{1'b1}}))
        else $error("clipped result not saturated");

    a_rows_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v && !out_ready |=> r_s2_v && $stable(r_s2_last))
        else $error("row-sum stage changed while the output was stalled");

endmodule

// ===== rtl/conv5x5_ternary_abs_unit.sv =====
// Channel   Dir  Handshake                    Payload
// config    in   psel+penable+pwrite, pready  paddr, pwdata / prdata
// pixels    in   i_valid / o_ready            i_pixel_in, i_flush
// results   out  o_valid / i_ready            o_pixel_out, o_clipped, o_frame_last
//
// One beat per clock on both streams while nothing stalls; a beat lands in the window
// register when accepted, then moves through the row-sum register to the output register.
// The first result of a frame comes with beat 2*width+2; flush beats drain the rest.
// Reset is synchronous and clears counters, valid flags and the config registers; the
// line buffer is not cleared, and taps that fall outside the frame are masked instead.
// A stalled result backs up through the three stages; o_ready falls only when all
// of them hold a result.
module conv5x5_ternary_abs_unit import c5ta_pkg::*; #(
    parameter int MAX_WIDTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIX_W-1:0]   i_pixel_in,
    input  logic               i_flush,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pixel_out,
    output logic               o_clipped,
    output logic               o_frame_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [GEO_W-1:0]   r_frame_width;
    logic [GEO_W-1:0]   r_frame_height;
    logic [COEFS_W-1:0] r_kernel_coeffs;

    logic               cfg_we;
    logic [WW-1:0]      width_eff;
    logic [GEO_W-1:0]   height_eff;

    logic               s1_valid;
    logic               s1_ready;
    t_win               s1_win;
    t_tag               s1_tag;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= GEO_W'(FRAME_WIDTH_RST);
            r_frame_height  <= GEO_W'(MAX_HEIGHT);
            r_kernel_coeffs <= '0;
        end else if (cfg_we) begin
            unique case (paddr[PADDR_W-1:REG_LSB])
                REG_FRAME_WIDTH:   r_frame_width   <= pwdata[GEO_W-1:0];
                REG_FRAME_HEIGHT:  r_frame_height  <= pwdata[GEO_W-1:0];
                REG_KERNEL_COEFFS: r_kernel_coeffs <= pwdata[COEFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:REG_LSB])
            REG_FRAME_WIDTH:   prdata = PDATA_W'(r_frame_width);
            REG_FRAME_HEIGHT:  prdata = PDATA_W'(r_frame_height);
            REG_KERNEL_COEFFS: prdata = PDATA_W'(r_kernel_coeffs);
            default:           prdata = '0;
        endcase
    end

    // A geometry of zero acts as one; oversize values clamp to the maximum.
    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = WW'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_frame_width);
        end

        if (r_frame_height == '0) begin
            height_eff = GEO_W'(1);
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            height_eff = GEO_W'(MAX_HEIGHT);
        end else begin
            height_eff = r_frame_height;
        end
    end

    c5ta_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel_in (i_pixel_in),
        .i_flush    (i_flush),
        .o_valid    (s1_valid),
        .i_ready    (s1_ready),
        .o_win      (s1_win),
        .o_tag      (s1_tag)
    );

    c5ta_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coeffs     (r_kernel_coeffs),
        .i_valid      (s1_valid),
        .o_ready      (s1_ready),
        .i_win        (s1_win),
        .i_tag        (s1_tag),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_out  (o_pixel_out),
        .o_clipped    (o_clipped),
        .o_frame_last (o_frame_last)
    );

endmodule
